FILE: rtl/fmrq_pkg.sv
// Shared types and constants of the framed message receive queue.
`default_nettype none
package fmrq_pkg;

  localparam int SLOT_BYTES = 32;
  localparam int SLOT_COUNT = 8;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int IDX_W     = $clog2(SLOT_BYTES);
  localparam int PTR_W     = $clog2(SLOT_COUNT);
  localparam int ADDR_W    = $clog2(SLOT_COUNT * SLOT_BYTES);
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd2;
  localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'd3;
  localparam logic [BYTE_W-1:0] TERMINATOR       = 8'd0;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 1'd1;

  localparam logic ACT_RX_BYTE = 1'b0;
  localparam logic ACT_PULL    = 1'b1;

  typedef enum logic [1:0] {
    RS_EMPTY  = 2'd0,
    RS_NORMAL = 2'd1,
    RS_FULL   = 2'd2
  } ring_status_t;

  typedef enum logic {
    PS_IDLE,
    PS_PULL
  } pull_state_t;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] msg_byte;
    logic [LEN_W-1:0]  msg_length;
    logic              queue_was_empty;
    logic              last_of_run;
  } out_word_t;

endpackage
`default_nettype wire

FILE: rtl/framed_message_receive_queue_top.sv
// Framed message receiver: a ring of message slots held in one byte memory.
//
// Input words carry an action and a byte. For a received byte (action 0),
// a start byte opens a frame in the slot at the write pointer
// (dropped when every slot holds a message), data bytes are stored, and an
// end byte stores a zero terminator and commits the slot.
// A pull (action 1) returns the oldest message one word per byte, terminator
// included, with last_of_run on the final word; an empty ring gives one word
// with queue_was_empty set. While a pull runs, in_stall is high.
// An accepted pull enters the pull state; each byte read passes the read
// data register, then the output register. The single read port gives one
// byte per cycle unless out_stall holds the words; the input is held for
// the pull, and the next word is taken in the cycle after the last read.
// When the receiver raises out_stall, the output register and the read data
// register hold their words and no new read is issued until one moves on.
// Reset (rst, synchronous) empties the ring, closes any open frame and loads
// start byte 2 and end byte 3; slot memory contents are not cleared.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered.
`default_nettype none
module framed_message_receive_queue_top
  import fmrq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_data
);

  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] end_byte;

  logic [BYTE_W-1:0] slot_mem [SLOT_COUNT*SLOT_BYTES];
  logic [BYTE_W-1:0] mem_q;
  logic [LEN_W-1:0]  slot_lengths [SLOT_COUNT];

  logic [PTR_W-1:0] read_pointer;
  logic [PTR_W-1:0] write_pointer;
  ring_status_t     ring_status;
  logic             frame_open;
  logic [IDX_W-1:0] fill_count;

  pull_state_t      state;
  pull_state_t      state_next;
  logic [LEN_W-1:0] pull_len;
  logic             pull_empty;
  logic [IDX_W-1:0] pull_idx;

  // Stage between the memory read and the output register.
  logic             s1_valid;
  logic [LEN_W-1:0] s1_len;
  logic             s1_empty;
  logic             s1_last;
  logic             s1_zero;

  logic             accept;
  logic             issue;
  logic             s1_move;
  logic             pull_last;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] rp_inc;
  logic             mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] wr_data;

  assign accept  = in_valid && !in_stall;
  assign s1_move = s1_valid && (!out_valid || !out_stall);
  assign wp_inc  = (write_pointer == PTR_W'(SLOT_COUNT - 1)) ? '0
                                                             : write_pointer + PTR_W'(1);
  assign rp_inc  = (read_pointer == PTR_W'(SLOT_COUNT - 1)) ? '0
                                                            : read_pointer + PTR_W'(1);
  assign pull_last = pull_empty || (pull_len == '0)
                     || (LEN_W'(pull_idx) + LEN_W'(1) == pull_len);

  assign wr_addr = ADDR_W'(write_pointer) * ADDR_W'(SLOT_BYTES) + ADDR_W'(fill_count);
  assign rd_addr = ADDR_W'(read_pointer) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pull_idx);
  assign mem_we  = accept && (in_data.action == ACT_RX_BYTE) && frame_open;
  assign wr_data = (in_data.rx_byte == end_byte) ? TERMINATOR : in_data.rx_byte;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      PS_IDLE: begin
        if (accept && in_data.action == ACT_PULL) begin
          state_next = PS_PULL;
        end
      end
      PS_PULL: begin
        if (issue && pull_last) begin
          state_next = PS_IDLE;
        end
      end
      default: state_next = PS_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    case (state)
      PS_IDLE: in_stall = 1'b0;
      PS_PULL: issue = !s1_valid || s1_move;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      mem_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= START_BYTE_RESET;
      end_byte      <= END_BYTE_RESET;
      read_pointer  <= '0;
      write_pointer <= '0;
      ring_status   <= RS_EMPTY;
      frame_open    <= 1'b0;
      fill_count    <= '0;
      state         <= PS_IDLE;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_lengths[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_START_BYTE: start_byte <= cfg_data;
          REG_END_BYTE:   end_byte   <= cfg_data;
          default:        start_byte <= start_byte;
        endcase
      end

      if (accept && in_data.action == ACT_RX_BYTE) begin
        if (!frame_open) begin
          if (in_data.rx_byte == start_byte && ring_status != RS_FULL) begin
            frame_open <= 1'b1;
            fill_count <= '0;
          end
        end else if (in_data.rx_byte == end_byte) begin
          slot_lengths[write_pointer] <= LEN_W'(fill_count) + LEN_W'(1);
          write_pointer <= wp_inc;
          ring_status   <= (wp_inc == read_pointer) ? RS_FULL : RS_NORMAL;
          frame_open    <= 1'b0;
        end else begin
          fill_count <= (fill_count == IDX_W'(SLOT_BYTES - 1)) ? '0
                                                               : fill_count + IDX_W'(1);
        end
      end

      if (accept && in_data.action == ACT_PULL) begin
        pull_empty <= (ring_status == RS_EMPTY);
        pull_len   <= (ring_status == RS_EMPTY) ? '0 : slot_lengths[read_pointer];
        pull_idx   <= '0;
      end

      if (issue) begin
        s1_valid <= 1'b1;
        s1_len   <= pull_len;
        s1_empty <= pull_empty;
        s1_last  <= pull_last;
        s1_zero  <= pull_empty || (pull_len == '0);
        pull_idx <= pull_idx + IDX_W'(1);
        // The slot is freed once its last byte has been read.
        if (pull_last && !pull_empty) begin
          read_pointer <= rp_inc;
          ring_status  <= (rp_inc == write_pointer) ? RS_EMPTY : RS_NORMAL;
        end
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        out_valid <= 1'b1;
        out_data.msg_byte        <= s1_zero ? TERMINATOR : mem_q;
        out_data.msg_length      <= s1_len;
        out_data.queue_was_empty <= s1_empty;
        out_data.last_of_run     <= s1_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_empty_word_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.queue_was_empty |-> out_data.last_of_run)
    else $error("empty pull word without last flag");

  a_full_pointers: assert property (@(posedge clk) disable iff (rst)
    (ring_status == RS_FULL) || (ring_status == RS_EMPTY) |-> write_pointer == read_pointer)
    else $error("ring status disagrees with pointers");

  a_open_not_full: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> ring_status != RS_FULL)
    else $error("frame open while ring is full");

endmodule
`default_nettype wire
